FILE: design/fsw_pkg.sv
// Shared types and constants for the frame-sync pulse and watchdog unit.
// No dependencies; used by fsw_core and the top level.
`timescale 1ns / 1ps

package fsw_pkg;

    localparam int TIME_BITS   = 32;
    localparam int PERIOD_BITS = 20;
    localparam int PULSE_BITS  = 10;
    localparam int TMO_BITS    = 16;
    localparam int CFG_BITS    = 20;
    localparam int CFG_IDX_BITS = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd2;

    // item op codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CAPTURE = 3'd1;
    localparam logic [2:0] OP_COMPARE = 3'd2;
    localparam logic [2:0] OP_SETMODE = 3'd3;
    localparam logic [2:0] OP_EXPECT  = 3'd4;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RST  = 20'd16667;
    localparam logic [PULSE_BITS-1:0]  PULSE_RST   = 10'd10;
    localparam logic [TMO_BITS-1:0]    TIMEOUT_RST = 16'd100;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] frame_period;
        logic [PULSE_BITS-1:0]  pulse_low_us;
        logic [TMO_BITS-1:0]    timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           op;
        logic [TIME_BITS-1:0] event_time;
        logic [TIME_BITS-1:0] now_time;
        logic [1:0]           new_mode;
        logic                 expect_flag;
    } in_item_t;

    typedef struct packed {
        logic                 line_low;
        logic                 compare_valid;
        logic [TIME_BITS-1:0] next_compare;
        logic                 sync_pulse;
        logic [TIME_BITS-1:0] sync_time;
        logic [31:0]          sync_count;
        logic [TIME_BITS-1:0] period_last;
        logic [TIME_BITS-1:0] period_min;
        logic [TIME_BITS-1:0] period_max;
        logic                 alive;
        logic [31:0]          lost_count;
        logic [31:0]          late_count;
    } out_item_t;

endpackage

FILE: design/fsw_core.sv
// State and single-pass update logic of the frame-sync unit.
// Depends on fsw_pkg; instantiated by frame_sync_pulse_and_watchdog_unit.
`timescale 1ns / 1ps

module fsw_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  fsw_pkg::in_item_t  item,
    input  fsw_pkg::cfg_t      cfg,
    output fsw_pkg::out_item_t res
);

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_MASTER   = 2'd1,
        MODE_SLAVE    = 2'd2,
        MODE_FORCED   = 2'd3
    } mode_t;

    localparam int TB = fsw_pkg::TIME_BITS;

    mode_t          mode_reg, mode_next;
    logic           expecting_reg, expecting_next;
    logic [31:0]    ms_reg, ms_next;
    logic           have_first_reg, have_first_next;
    logic           low_phase_reg, low_phase_next;
    logic [1:0]     dither_reg, dither_next;
    logic [TB-1:0]  last_edge_reg, last_edge_next;
    logic [31:0]    edge_count_reg, edge_count_next;
    logic [TB-1:0]  last_period_reg, last_period_next;
    logic [TB-1:0]  min_period_reg, min_period_next;
    logic [TB-1:0]  max_period_reg, max_period_next;
    logic           alive_reg, alive_next;
    logic [31:0]    loss_reg, loss_next;
    logic [31:0]    late_reg, late_next;
    logic [TB-1:0]  compare_reg, compare_next;

    logic [TB-1:0]  period_ext;
    logic [TB-1:0]  pulse_ext;
    logic [1:0]     dither_adv;
    logic [TB-1:0]  dith_period;
    logic [TB-1:0]  rise;
    logic [TB-1:0]  late_diff;
    logic [31:0]    ms_inc;
    logic           do_edge;
    logic [TB-1:0]  edge_dt;
    logic           cvalid;

    assign period_ext  = TB'(cfg.frame_period);
    assign pulse_ext   = TB'(cfg.pulse_low_us);
    assign dither_adv  = (dither_reg == 2'd2) ? 2'd0 : dither_reg + 2'd1;
    // every third period is one microsecond short
    assign dith_period = (dither_adv == 2'd0) ? period_ext - TB'(1) : period_ext;
    assign rise        = item.event_time + pulse_ext;
    assign late_diff   = item.now_time - rise;
    assign ms_inc      = (ms_reg == 32'hFFFF_FFFF) ? ms_reg : ms_reg + 32'd1;
    assign edge_dt     = item.event_time - last_edge_reg;

    always_comb begin
        mode_next        = mode_reg;
        expecting_next   = expecting_reg;
        ms_next          = ms_reg;
        have_first_next  = have_first_reg;
        low_phase_next   = low_phase_reg;
        dither_next      = dither_reg;
        last_edge_next   = last_edge_reg;
        edge_count_next  = edge_count_reg;
        last_period_next = last_period_reg;
        min_period_next  = min_period_reg;
        max_period_next  = max_period_reg;
        alive_next       = alive_reg;
        loss_next        = loss_reg;
        late_next        = late_reg;
        compare_next     = compare_reg;
        do_edge          = 1'b0;
        cvalid           = 1'b0;

        case (item.op)
            fsw_pkg::OP_TICK: begin
                if (expecting_reg && have_first_reg) begin
                    ms_next = ms_inc;
                    if (ms_inc >= 32'(cfg.timeout_ms) && alive_reg) begin
                        alive_next = 1'b0;
                        loss_next  = loss_reg + 32'd1;
                    end
                end
            end
            fsw_pkg::OP_CAPTURE: begin
                if (mode_reg == MODE_SLAVE) begin
                    do_edge = 1'b1;
                end
            end
            fsw_pkg::OP_COMPARE: begin
                if (mode_reg == MODE_MASTER) begin
                    cvalid = 1'b1;
                    if (!low_phase_reg) begin
                        do_edge = 1'b1;
                        if (!late_diff[TB-1]) begin
                            // rise already passed: release now, go to next fall
                            compare_next   = item.event_time + dith_period;
                            low_phase_next = 1'b0;
                            dither_next    = dither_adv;
                            late_next      = late_reg + 32'd1;
                        end else begin
                            compare_next   = rise;
                            low_phase_next = 1'b1;
                        end
                    end else begin
                        low_phase_next = 1'b0;
                        dither_next    = dither_adv;
                        compare_next   = item.event_time + dith_period - pulse_ext;
                    end
                end
            end
            fsw_pkg::OP_SETMODE: begin
                ms_next = 32'd0;
                case (item.new_mode)
                    MODE_MASTER: begin
                        low_phase_next  = 1'b0;
                        have_first_next = 1'b0;
                        edge_count_next = 32'd0;
                        compare_next    = item.now_time + period_ext;
                        cvalid          = 1'b1;
                        mode_next       = MODE_MASTER;
                        expecting_next  = 1'b1;
                    end
                    MODE_SLAVE: begin
                        have_first_next = 1'b0;
                        edge_count_next = 32'd0;
                        mode_next       = MODE_SLAVE;
                        expecting_next  = 1'b1;
                    end
                    MODE_RELEASED: begin
                        have_first_next = 1'b0;
                        edge_count_next = 32'd0;
                        mode_next       = MODE_RELEASED;
                        expecting_next  = 1'b0;
                        alive_next      = 1'b0;
                    end
                    default: begin
                        mode_next      = MODE_FORCED;
                        expecting_next = 1'b0;
                        alive_next     = 1'b0;
                    end
                endcase
            end
            fsw_pkg::OP_EXPECT: begin
                expecting_next = item.expect_flag;
                ms_next        = 32'd0;
                if (!item.expect_flag) begin
                    alive_next = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (do_edge) begin
            if (have_first_reg) begin
                last_period_next = edge_dt;
                if (edge_dt < min_period_reg) begin
                    min_period_next = edge_dt;
                end
                if (edge_dt > max_period_reg) begin
                    max_period_next = edge_dt;
                end
            end
            have_first_next = 1'b1;
            last_edge_next  = item.event_time;
            edge_count_next = edge_count_reg + 32'd1;
            alive_next      = 1'b1;
            ms_next         = 32'd0;
        end
    end

    always_comb begin
        res.line_low      = (mode_next == MODE_FORCED) ||
                            (mode_next == MODE_MASTER && low_phase_next);
        res.compare_valid = cvalid;
        res.next_compare  = cvalid ? compare_next : '0;
        res.sync_pulse    = do_edge;
        res.sync_time     = do_edge ? item.event_time : '0;
        res.sync_count    = edge_count_next;
        res.period_last   = last_period_next;
        res.period_min    = min_period_next;
        res.period_max    = max_period_next;
        res.alive         = alive_next;
        res.lost_count    = loss_next;
        res.late_count    = late_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RELEASED;
            expecting_reg   <= 1'b0;
            ms_reg          <= '0;
            have_first_reg  <= 1'b0;
            low_phase_reg   <= 1'b0;
            dither_reg      <= '0;
            last_edge_reg   <= '0;
            edge_count_reg  <= '0;
            last_period_reg <= '0;
            min_period_reg  <= '1;
            max_period_reg  <= '0;
            alive_reg       <= 1'b0;
            loss_reg        <= '0;
            late_reg        <= '0;
            compare_reg     <= '0;
        end else if (step) begin
            mode_reg        <= mode_next;
            expecting_reg   <= expecting_next;
            ms_reg          <= ms_next;
            have_first_reg  <= have_first_next;
            low_phase_reg   <= low_phase_next;
            dither_reg      <= dither_next;
            last_edge_reg   <= last_edge_next;
            edge_count_reg  <= edge_count_next;
            last_period_reg <= last_period_next;
            min_period_reg  <= min_period_next;
            max_period_reg  <= max_period_next;
            alive_reg       <= alive_next;
            loss_reg        <= loss_next;
            late_reg        <= late_next;
            compare_reg     <= compare_next;
        end
    end

endmodule

FILE: design/frame_sync_pulse_and_watchdog_unit.sv
// Path: an item accepted into the input register goes through the combinational
// update in fsw_core into the result register; it waits in the input register
// while the result register still holds a result that waits on m_ready.
// Throughput: one item per cycle; the result register only holds the input
// stage back while a result waits on m_ready.
// Reset: synchronous, active low; clears all state and statistics (minimum
// period to all ones) and loads the register defaults. Depends on fsw_pkg, fsw_core.
`timescale 1ns / 1ps

module frame_sync_pulse_and_watchdog_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fsw_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fsw_pkg::out_item_t                m_item,
    input  logic                              cfg_wr_en,
    input  logic [fsw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [fsw_pkg::CFG_BITS-1:0]      cfg_wdata
);

    fsw_pkg::cfg_t      cfg_reg;
    fsw_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    fsw_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;
    fsw_pkg::out_item_t res;
    logic               step;

    // item moves from input register to result register when the latter frees up
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    fsw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_period <= fsw_pkg::PERIOD_RST;
            cfg_reg.pulse_low_us <= fsw_pkg::PULSE_RST;
            cfg_reg.timeout_ms   <= fsw_pkg::TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fsw_pkg::REG_PERIOD:
                    cfg_reg.frame_period <= cfg_wdata[fsw_pkg::PERIOD_BITS-1:0];
                fsw_pkg::REG_PULSE:
                    cfg_reg.pulse_low_us <= cfg_wdata[fsw_pkg::PULSE_BITS-1:0];
                fsw_pkg::REG_TIMEOUT:
                    cfg_reg.timeout_ms <= cfg_wdata[fsw_pkg::TMO_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_item_reg <= res;
        end
    end

endmodule
